@@ hdl/yc2argb_pkg.sv @@
// Package for the YCrCb plus transparency to ARGB converter.
// Holds the item types and the fixed-point constants of the conversion.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package yc2argb_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned FracBits = 10;
  localparam int unsigned SumW     = 21;

  localparam logic [ChanW-1:0] LumaMin      = 8'd16;
  localparam logic [ChanW-1:0] LumaMax      = 8'd235;
  localparam logic [ChanW-1:0] ChromaMin    = 8'd16;
  localparam logic [ChanW-1:0] ChromaMax    = 8'd240;
  localparam logic [ChanW-1:0] LumaOffset   = 8'd16;
  localparam logic [ChanW:0]   ChromaOffset = 9'd128;
  localparam logic [ChanW-1:0] ChanMax      = 8'hFF;

  localparam logic signed [SumW-1:0] CoefY     = 21'sd1192;
  localparam logic signed [SumW-1:0] CoefRCr   = 21'sd1634;
  localparam logic signed [SumW-1:0] CoefGCr   = 21'sd833;
  localparam logic signed [SumW-1:0] CoefGCb   = 21'sd401;
  localparam logic signed [SumW-1:0] CoefBCb   = 21'sd2065;
  localparam logic signed [SumW-1:0] RoundHalf = 21'sd512;

  typedef struct packed {
    logic [ChanW-1:0] luma;
    logic [ChanW-1:0] chroma_red;
    logic [ChanW-1:0] chroma_blue;
    logic [ChanW-1:0] transparency;
  } ycrcbt_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } argb_t;

endpackage

`default_nettype wire

@@ hdl/yc2argb_if.sv @@
// Valid/ready channel interfaces for the converter's input and result items.
// Depends on yc2argb_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface yc2argb_in_if;
  import yc2argb_pkg::*;

  logic    valid;
  logic    ready;
  ycrcbt_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yc2argb_out_if;
  import yc2argb_pkg::*;

  logic  valid;
  logic  ready;
  argb_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/ycrcbt_to_argb_converter.sv @@
// A result is offered once its item has passed the input register and the
// result register; a stall at the output can hold it in the input register.
// Throughput: one item per cycle unless the output stalls; the input register
// and the result register each hold one item, and the conversion between them is a single pass.
// Reset clears both valid flags; the payload registers are not reset.
// Depends on yc2argb_pkg, yc2argb_if and yc2argb_core.
`timescale 1ns / 1ps
`default_nettype none

module ycrcbt_to_argb_converter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  yc2argb_in_if.sink           in_i,
  yc2argb_out_if.source        out_o
);
  import yc2argb_pkg::*;

  ycrcbt_t pix_q;
  logic    pix_valid_q;
  argb_t   argb_d;
  argb_t   argb_q;
  logic    argb_valid_q;
  logic    pix_adv;
  logic    in_take;

  assign pix_adv    = pix_valid_q && (!argb_valid_q || out_o.ready);
  assign in_i.ready = !pix_valid_q || pix_adv;
  assign in_take    = in_i.valid && in_i.ready;

  yc2argb_core u_core (
    .pix_i  (pix_q),
    .argb_o (argb_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q  <= 1'b0;
      argb_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        pix_valid_q <= in_i.valid;
      end
      if (pix_adv) begin
        argb_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        argb_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q <= in_i.data;
    end
    if (pix_adv) begin
      argb_q <= argb_d;
    end
  end

  assign out_o.valid = argb_valid_q;
  assign out_o.data  = argb_q;

`ifndef SYNTHESIS
  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_valid_q |-> in_i.ready)
    else $error("Input stage is empty but does not accept an item.");

  a_stalled_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_q && !pix_adv |=> pix_valid_q && $stable(pix_q))
    else $error("Stalled item left the input stage.");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(argb_valid_q) |-> $past(pix_valid_q))
    else $error("Result appeared without an item in the input stage.");

  a_taken_or_refilled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    argb_valid_q && out_o.ready && !pix_valid_q |=> !argb_valid_q)
    else $error("Delivered result was offered again.");
`endif

endmodule

`default_nettype wire

@@ hdl/yc2argb_core.sv @@
// Combinational colour conversion of one item: clamping, offset removal,
// Q10 products, rounding and saturation; a zero luma gives transparent white. Depends on yc2argb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yc2argb_core (
  input  yc2argb_pkg::ycrcbt_t pix_i,
  output yc2argb_pkg::argb_t   argb_o
);
  import yc2argb_pkg::*;

  function automatic logic [ChanW-1:0] clamp(input logic [ChanW-1:0] v,
                                             input logic [ChanW-1:0] lo,
                                             input logic [ChanW-1:0] hi);
    logic [ChanW-1:0] r;
    priority if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ChanW-1:0] to_chan(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0]     biased;
    logic [SumW-2-FracBits:0]   whole;
    logic [ChanW-1:0]           r;
    biased = s + RoundHalf;
    whole  = biased[SumW-2:FracBits];
    priority if (biased[SumW-1]) begin
      r = '0;
    end else if (|whole[SumW-2-FracBits:ChanW]) begin
      r = ChanMax;
    end else begin
      r = whole[ChanW-1:0];
    end
    return r;
  endfunction

  logic [ChanW-1:0]        y_off;
  logic signed [ChanW:0]   cr_off;
  logic signed [ChanW:0]   cb_off;
  logic signed [SumW-1:0]  y_s;
  logic signed [SumW-1:0]  cr_s;
  logic signed [SumW-1:0]  cb_s;
  logic signed [SumW-1:0]  base;
  logic signed [SumW-1:0]  sum_r;
  logic signed [SumW-1:0]  sum_g;
  logic signed [SumW-1:0]  sum_b;

  always_comb begin
    y_off  = clamp(pix_i.luma, LumaMin, LumaMax) - LumaOffset;
    cr_off = $signed({1'b0, clamp(pix_i.chroma_red, ChromaMin, ChromaMax)})
             - $signed(ChromaOffset);
    cb_off = $signed({1'b0, clamp(pix_i.chroma_blue, ChromaMin, ChromaMax)})
             - $signed(ChromaOffset);
    y_s    = $signed({{(SumW-ChanW){1'b0}}, y_off});
    cr_s   = SumW'(cr_off);
    cb_s   = SumW'(cb_off);
    base   = CoefY * y_s;
    sum_r  = base + CoefRCr * cr_s;
    sum_g  = base - CoefGCr * cr_s - CoefGCb * cb_s;
    sum_b  = base + CoefBCb * cb_s;

    if (pix_i.luma == '0) begin
      argb_o.alpha = '0;
      argb_o.red   = ChanMax;
      argb_o.green = ChanMax;
      argb_o.blue  = ChanMax;
    end else begin
      argb_o.alpha = ChanMax - pix_i.transparency;
      argb_o.red   = to_chan(sum_r);
      argb_o.green = to_chan(sum_g);
      argb_o.blue  = to_chan(sum_b);
    end
  end

endmodule

`default_nettype wire
